@@ rtl/core/top_k_keeper_replace_min_macros.svh @@
// Assertion macros for the top-k keeper block.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef TOP_K_KEEPER_REPLACE_MIN_MACROS_SVH
`define TOP_K_KEEPER_REPLACE_MIN_MACROS_SVH
`ifndef SYNTHESIS
`define TKK_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top_k_keeper assertion failed");
`define TKK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top_k_keeper assertion failed");
`else
`define TKK_ASSERT_IMP(label, ante, cons)
`define TKK_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/tkk_pkg.sv @@
// Package for the top-k keeper: request types, table entry type and defaults.
// Depends on nothing.
package tkk_pkg;

  localparam int KEY_W         = 24;
  localparam int LEN_W         = 2;
  localparam int SCORE_W       = 32;
  localparam int OUT_SLOT_W    = 7;
  localparam int CAPACITY_DEF  = 128;
  localparam int MAX_CHARS_DEF = 3;

  typedef struct packed {
    logic [KEY_W-1:0]   ngram_key;
    logic [LEN_W-1:0]   ngram_length;
    logic [SCORE_W-1:0] score;
  } in_req_t;

  typedef struct packed {
    logic                  accepted;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  replaced;
    logic [KEY_W-1:0]      evicted_key;
    logic [LEN_W-1:0]      evicted_length;
    logic [SCORE_W-1:0]    evicted_score;
  } out_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [LEN_W-1:0]   length;
    logic [SCORE_W-1:0] score;
  } entry_t;

endpackage

@@ rtl/core/tkk_in_if.sv @@
// Input channel of the top-k keeper: valid, ready and one n-gram request.
// Depends on tkk_pkg.
interface tkk_in_if;
  import tkk_pkg::*;

  logic    valid;
  logic    ready;
  in_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/tkk_out_if.sv @@
// Result channel of the top-k keeper: valid, ready and one result request.
// Depends on tkk_pkg.
interface tkk_out_if;
  import tkk_pkg::*;

  logic     valid;
  logic     ready;
  out_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/top_k_keeper_replace_min.sv @@
// Top level of the top-k keeper: table memory, scan sequencer and result register.
// Depends on tkk_pkg, tkk_in_if, tkk_out_if and top_k_keeper_replace_min_macros.svh.
//
// The block keeps the CAPACITY highest-scoring n-grams. Each request on in_ch carries a
// key, a length and a score; each one produces exactly one request on out_ch telling
// whether the entry was stored, in which slot, and what was evicted.
// Both channels use valid/ready; a request moves when both are high.
// in_ch.ready is high only while the sequencer is idle, so one request is handled at a time.
// Path from acceptance until the result stands in the output register:
//   table not yet full:              entry written from idle, then done
//   table full, minimum cached:      read of the cached slot, then done
//   table full, minimum not cached:  scan of every slot, read, then done
// With the receiver keeping up, in_ch.ready returns as the result moves from the
// sequencer into the output register.
// The minimum scan reads one score per cycle through the single read port of the table
// memory. The cache is lost after every replacement.
// The output register decouples the sides: a new request is taken while a result still
// waits; a finished result then waits in the sequencer until the output register is free.
// Synchronous reset empties the table (fill count zero, no cached minimum); the table
// memory itself is not cleared and needs no clearing pass.
`include "top_k_keeper_replace_min_macros.svh"

module top_k_keeper_replace_min #(
  parameter int CAPACITY  = tkk_pkg::CAPACITY_DEF,
  parameter int MAX_CHARS = tkk_pkg::MAX_CHARS_DEF
) (
  input logic     clk,
  input logic     rst_n,
  tkk_in_if.sink  in_ch,
  tkk_out_if.source out_ch
);
  import tkk_pkg::*;

  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_BITS = (MAX_CHARS * 8 >= KEY_W) ? KEY_W : MAX_CHARS * 8;
  localparam logic [KEY_W-1:0] KEY_MASK =
    KEY_W'(((KEY_W+1)'(1) << KEY_BITS) - (KEY_W+1)'(1));

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [SLOT_W-1:0] worst_slot_r, worst_slot_nxt;
  logic              worst_known_r, worst_known_nxt;
  logic [SLOT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [SLOT_W-1:0] min_idx_r, min_idx_nxt;
  logic [SCORE_W-1:0] min_score_r, min_score_nxt;
  in_req_t           cur_r, cur_nxt;
  out_req_t          res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_req_t          out_req_r, out_req_nxt;

  entry_t            mem [CAPACITY];
  entry_t            rd_data_r;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              table_full;
  logic [KEY_W-1:0]  key_masked;
  logic              scan_lower;
  logic [SLOT_W-1:0] scan_best;
  logic              scan_last;

  assign table_full = (fill_cnt_r >= CNT_W'(CAPACITY));
  assign key_masked = in_ch.payload.ngram_key & KEY_MASK;
  assign scan_lower = (scan_idx_r == '0) || (rd_data_r.score < min_score_r);
  assign scan_best  = scan_lower ? scan_idx_r : min_idx_r;
  assign scan_last  = (scan_idx_r == SLOT_W'(CAPACITY - 1));

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_req_r;

  always_comb begin
    state_nxt       = state_r;
    fill_cnt_nxt    = fill_cnt_r;
    worst_slot_nxt  = worst_slot_r;
    worst_known_nxt = worst_known_r;
    scan_idx_nxt    = scan_idx_r;
    min_idx_nxt     = min_idx_r;
    min_score_nxt   = min_score_r;
    cur_nxt         = cur_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_req_nxt     = out_req_r;
    rd_addr         = worst_slot_r;
    wr_en           = 1'b0;
    wr_addr         = worst_slot_r;
    wr_data         = '{key: cur_r.ngram_key, length: cur_r.ngram_length, score: cur_r.score};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cur_nxt = '{ngram_key: key_masked, ngram_length: in_ch.payload.ngram_length,
                      score: in_ch.payload.score};
          if (!table_full) begin
            wr_en           = 1'b1;
            wr_addr         = fill_cnt_r[SLOT_W-1:0];
            wr_data         = '{key: key_masked, length: in_ch.payload.ngram_length,
                                score: in_ch.payload.score};
            fill_cnt_nxt    = fill_cnt_r + CNT_W'(1);
            worst_known_nxt = 1'b0;
            res_nxt          = '0;
            res_nxt.accepted = 1'b1;
            res_nxt.slot     = OUT_SLOT_W'(fill_cnt_r[SLOT_W-1:0]);
            state_nxt        = S_DONE;
          end else if (worst_known_r) begin
            rd_addr   = worst_slot_r;
            state_nxt = S_READ;
          end else begin
            rd_addr      = '0;
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        min_score_nxt = scan_lower ? rd_data_r.score : min_score_r;
        min_idx_nxt   = scan_best;
        if (scan_last) begin
          worst_slot_nxt  = scan_best;
          worst_known_nxt = 1'b1;
          rd_addr         = scan_best;
          state_nxt       = S_READ;
        end else begin
          scan_idx_nxt = scan_idx_r + SLOT_W'(1);
          rd_addr      = scan_idx_r + SLOT_W'(1);
        end
      end
      S_READ: begin
        res_nxt = '0;
        if (cur_r.score > rd_data_r.score) begin
          wr_en                  = 1'b1;
          wr_addr                = worst_slot_r;
          worst_known_nxt        = 1'b0;
          res_nxt.accepted       = 1'b1;
          res_nxt.slot           = OUT_SLOT_W'(worst_slot_r);
          res_nxt.replaced       = 1'b1;
          res_nxt.evicted_key    = rd_data_r.key;
          res_nxt.evicted_length = rd_data_r.length;
          res_nxt.evicted_score  = rd_data_r.score;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_req_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fill_cnt_r    <= '0;
      worst_slot_r  <= '0;
      worst_known_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fill_cnt_r    <= fill_cnt_nxt;
      worst_slot_r  <= worst_slot_nxt;
      worst_known_r <= worst_known_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    min_idx_r   <= min_idx_nxt;
    min_score_r <= min_score_nxt;
    cur_r       <= cur_nxt;
    res_r       <= res_nxt;
    out_req_r   <= out_req_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  `TKK_ASSERT_IMP(a_fill_bounded, 1'b1, fill_cnt_r <= CNT_W'(CAPACITY))
  `TKK_ASSERT_IMP(a_cache_only_full, worst_known_r, table_full)
  `TKK_ASSERT_IMP(a_scan_only_full, state_r == S_SCAN, table_full && !worst_known_r)
  `TKK_ASSERT_NEXT(a_fill_one_step, in_ch.valid && in_ch.ready && !table_full,
                   state_r == S_DONE && res_r.accepted && !res_r.replaced)

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for top_k_keeper_replace_min: fills the table, checks ties at the
// minimum and runs random n-gram requests under varying idle and stall patterns.
// Depends on tkk_pkg, tkk_in_if, tkk_out_if and the top_k_keeper_replace_min RTL.
module tb;
  import tkk_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int KEEP_BITS = (8 * MAX_CHARS_DEF < KEY_W) ? 8 * MAX_CHARS_DEF : KEY_W;
  localparam logic [KEY_W-1:0] KEY_KEEP = {KEY_W{1'b1}} >> (KEY_W - KEEP_BITS);
  localparam int TAIL_CYCLES = CAP + 8;
  localparam longint RUN_LIMIT = 64'd50_000_000;
  localparam int PHASE_ITEMS = 454;

  logic clk;
  logic rst_n;

  tkk_in_if  in_ch();
  tkk_out_if out_ch();

  top_k_keeper_replace_min #(
    .CAPACITY (CAP),
    .MAX_CHARS(MAX_CHARS_DEF)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  entry_t      kept[CAP];
  int unsigned filled;
  int unsigned low_slot;
  bit          low_known;

  out_req_t    pending_results[$];
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned stored_total;
  int unsigned evicted_total;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                results_seen, name, got, want));
    end
  endtask

  // First slot holding the lowest score among the filled slots.
  function automatic int unsigned lowest_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < filled; i++) begin
      if (kept[i].score < kept[best].score) begin
        best = i;
      end
    end
    return best;
  endfunction

  function automatic out_req_t keep_best(input in_req_t req);
    out_req_t    res;
    entry_t      incoming;
    int unsigned victim;
    res = '0;
    incoming.key    = req.ngram_key & KEY_KEEP;
    incoming.length = req.ngram_length;
    incoming.score  = req.score;
    if (filled < CAP) begin
      kept[filled] = incoming;
      res.accepted = 1'b1;
      res.slot     = filled[OUT_SLOT_W-1:0];
      filled++;
      low_known = 1'b0;
      return res;
    end
    if (!low_known) begin
      low_slot  = lowest_slot();
      low_known = 1'b1;
    end
    victim = low_slot;
    if (req.score > kept[victim].score) begin
      res.accepted       = 1'b1;
      res.slot           = victim[OUT_SLOT_W-1:0];
      res.replaced       = 1'b1;
      res.evicted_key    = kept[victim].key;
      res.evicted_length = kept[victim].length;
      res.evicted_score  = kept[victim].score;
      kept[victim]       = incoming;
      low_known          = 1'b0;
    end
    return res;
  endfunction

  function automatic in_req_t ngram(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len,
                                    input logic [SCORE_W-1:0] score);
    in_req_t req;
    req.ngram_key    = key;
    req.ngram_length = len;
    req.score        = score;
    return req;
  endfunction

  // Most scores sit close to the current minimum so that ties and near misses stay common.
  function automatic in_req_t random_ngram();
    in_req_t            req;
    int unsigned        pick;
    logic [SCORE_W-1:0] floor_score;
    logic [SCORE_W:0]   sum;
    req.ngram_length = LEN_W'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) begin
      req.ngram_key = KEY_W'($urandom);
    end else begin
      req.ngram_key = KEY_W'($urandom)
                      & ({KEY_W{1'b1}} >> (8 * (MAX_CHARS_DEF - int'(req.ngram_length))));
    end
    floor_score = (filled == 0) ? '0 : kept[lowest_slot()].score;
    pick = $urandom_range(0, 49);
    if (pick < 20) begin
      sum = {1'b0, floor_score} + (SCORE_W+1)'($urandom_range(0, 4));
      sum = (sum == '0) ? sum : sum - (SCORE_W+1)'(1);
      req.score = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
    end else if (pick < 35) begin
      req.score = $urandom;
    end else if (pick < 42) begin
      req.score = $urandom_range(0, 255);
    end else if (pick == 42) begin
      req.score = '1;
    end else begin
      sum = {1'b0, floor_score} + (SCORE_W+1)'($urandom_range(1, 1000));
      req.score = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
    end
    return req;
  endfunction

  task automatic send_ngram(input in_req_t req);
    out_req_t want;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    want = keep_best(req);
    pending_results.insert(pending_results.size(), want);
    requests_sent++;
    if (want.accepted) stored_total++;
    if (want.replaced) evicted_total++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Planted scores put the unique minimum in the last slot and a tie at slots 0 and 64.
  task automatic test_fill_table();
    in_req_t req;
    for (int i = 0; i < CAP; i++) begin
      case (i)
        0:       req = ngram(24'h000000, 2'd0, 32'd3);
        1:       req = ngram(24'hFFFFFF, 2'd3, 32'hFFFFFFFF);
        2:       req = ngram(24'h000041, 2'd1, 32'hFFFFFFFE);
        3:       req = ngram(24'h004241, 2'd2, 32'h80000000);
        64:      req = ngram(24'h434241, 2'd3, 32'd3);
        CAP - 1: req = ngram(24'hFFFFFF, 2'd3, 32'd2);
        default: begin
          req = random_ngram();
          if (req.score < 16) req.score = req.score + 16;
        end
      endcase
      send_ngram(req);
    end
  endtask

  task automatic test_minimum_ties();
    send_ngram(ngram(24'h00005A, 2'd1, 32'd2));
    send_ngram(ngram(24'h000000, 2'd0, 32'd0));
    send_ngram(ngram(24'h000031, 2'd1, 32'd3));
    send_ngram(ngram(24'h000032, 2'd1, 32'd3));
    send_ngram(ngram(24'hABCDEF, 2'd3, 32'd9));
    send_ngram(ngram(24'h123456, 2'd2, 32'd9));
    send_ngram(ngram(24'h000033, 2'd1, 32'd2));
    send_ngram(ngram(24'hFFFFFF, 2'd3, 32'hFFFFFFFF));
    wait_drained();
  endtask

  task automatic test_random_phase(input int unsigned sender_pct, input int unsigned sink_pct,
                                   input int unsigned count);
    send_idle_pct = sender_pct;
    stall_pct     = sink_pct;
    repeat (count) send_ngram(random_ngram());
    wait_drained();
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    out_req_t got;
    out_req_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                  results_seen, got));
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 64'(got.accepted), 64'(want.accepted));
        check_field("slot", 64'(got.slot), 64'(want.slot));
        check_field("replaced", 64'(got.replaced), 64'(want.replaced));
        check_field("evicted_key", 64'(got.evicted_key), 64'(want.evicted_key));
        check_field("evicted_length", 64'(got.evicted_length), 64'(want.evicted_length));
        check_field("evicted_score", 64'(got.evicted_score), 64'(want.evicted_score));
      end
      results_seen++;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    filled        = 0;
    low_slot      = 0;
    low_known     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_table();
    test_minimum_ties();
    test_random_phase(0, 0, PHASE_ITEMS);
    test_random_phase(48, 0, PHASE_ITEMS);
    test_random_phase(0, 48, PHASE_ITEMS);
    test_random_phase(19, 19, PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d n-gram requests: %0d stored, %0d of them evicting the lowest entry.",
             requests_sent, stored_total, evicted_total);
    $display("Covered table fill, ties at the minimum, and idle and stall phases on both sides.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Run stopped after the time limit with %0d results outstanding.",
             pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ top_k_keeper_replace_min.f @@
+incdir+rtl/core
rtl/core/tkk_pkg.sv
rtl/core/tkk_in_if.sv
rtl/core/tkk_out_if.sv
rtl/core/top_k_keeper_replace_min.sv
verif/tb.sv
